[src/bsd_pkg.sv]
// Package with shared constants, types and the character decode function of the base64 decoder.
`timescale 1ns / 1ps
package bsd_pkg;

    localparam int MAX_CHARS_DEF   = 65535;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LENGTH   = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    localparam logic [6:0] SX_DIGIT_BASE = 7'd52;
    localparam logic [6:0] SX_PLUS       = 7'd62;
    localparam logic [6:0] SX_SLASH      = 7'd63;
    localparam logic [6:0] SX_PAD        = 7'd64;
    localparam logic [6:0] SX_BAD        = 7'd65;
    localparam logic [7:0] LOWER_OFFSET  = 8'd71;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      nbytes;
        logic [15:0]     base_count;
        logic            has_status;
        logic [1:0]      status;
        logic [15:0]     final_count;
    } t_cmd;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[8'd97:8'd122]}) begin
            v = c - LOWER_OFFSET;
        end else if (c inside {[8'd48:8'd57]}) begin
            v = c - 8'd48 + 8'(SX_DIGIT_BASE);
        end else if (c inside {[8'd65:8'd90]}) begin
            v = c - 8'd65;
        end else if (c == 8'd43) begin
            v = 8'(SX_PLUS);
        end else if (c == 8'd47) begin
            v = 8'(SX_SLASH);
        end else if (c == 8'd61) begin
            v = 8'(SX_PAD);
        end else begin
            v = 8'(SX_BAD);
        end
        return v[6:0];
    endfunction

endpackage

[src/bsd_if.sv]
// Stream interfaces for the character input and the decoded word output.
`timescale 1ns / 1ps
interface bsd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_code;
    logic [15:0] total_chars;
    logic        last_char;

    modport source (output valid, output char_code, output total_chars, output last_char,
                    input ready);
    modport sink (input valid, input char_code, input total_chars, input last_char,
                  output ready);
endinterface

interface bsd_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [1:0]  status_code;
    logic [15:0] byte_count;
    logic        last_item;

    modport source (output valid, output item_kind, output data_byte, output status_code,
                    output byte_count, output last_item, input ready);
    modport sink (input valid, input item_kind, input data_byte, input status_code,
                  input byte_count, input last_item, output ready);
endinterface

[src/bsd_front.sv]
// Front end: accepts characters, tracks messages and groups, and queues output commands.
`timescale 1ns / 1ps
module bsd_front #(
    parameter int MAX_CHARS = bsd_pkg::MAX_CHARS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_capacity,
    bsd_in_if.sink        in_ch,
    input  logic          i_full,
    output logic          o_push,
    output bsd_pkg::t_cmd o_cmd
);
    import bsd_pkg::*;

    logic             r_in_msg, n_in_msg;
    logic [1:0]       r_phase, n_phase;
    logic [2:0][6:0]  r_held, n_held;
    logic [15:0]      r_remaining, n_remaining;
    logic [15:0]      r_bytes, n_bytes;
    logic             r_stopped, n_stopped;
    logic [1:0]       r_status, n_status;

    logic             accept;
    logic [1:0]       s_phase;
    logic [15:0]      s_rem;
    logic [15:0]      s_bytes;
    logic             s_stop;
    logic [1:0]       s_status;
    logic [13:0]      groups_m1;
    logic [15:0]      groups_x3;
    logic             len_bad;
    logic [6:0]       code;
    logic [6:0]       ca, cb, cd;
    logic [16:0]      be17, cap17;
    logic [1:0]       nb;
    logic [15:0]      rem_next;
    logic             ending;

    assign in_ch.ready = !i_full;
    assign accept      = in_ch.valid && !i_full;

    always_comb begin
        groups_m1 = in_ch.total_chars[15:2] - 14'd1;
        groups_x3 = {1'b0, groups_m1, 1'b0} + {2'b00, groups_m1};
        len_bad   = (in_ch.total_chars == 16'd0) || (in_ch.total_chars[1:0] != 2'd0)
                    || ({16'd0, in_ch.total_chars} > 32'(MAX_CHARS));

        if (r_in_msg) begin
            s_phase  = r_phase;
            s_rem    = r_remaining;
            s_bytes  = r_bytes;
            s_stop   = r_stopped;
            s_status = r_status;
        end else begin
            s_phase = 2'd0;
            s_rem   = in_ch.total_chars;
            s_bytes = 16'd0;
            if (len_bad) begin
                s_stop   = 1'b1;
                s_status = ST_LENGTH;
            end else if (i_capacity <= groups_x3) begin
                s_stop   = 1'b1;
                s_status = ST_CAPACITY;
            end else begin
                s_stop   = 1'b0;
                s_status = ST_OK;
            end
        end

        code  = sextet_of(in_ch.char_code);
        ca    = r_held[0];
        cb    = r_held[1];
        cd    = r_held[2];
        be17  = {1'b0, s_bytes};
        cap17 = {1'b0, i_capacity};

        n_phase   = s_phase;
        n_held    = r_held;
        n_stopped = s_stop;
        n_status  = s_status;
        nb        = 2'd0;

        if (!s_stop) begin
            if (s_phase != 2'd3) begin
                n_held[s_phase] = code;
                n_phase         = s_phase + 2'd1;
            end else begin
                n_phase = 2'd0;
                if (ca >= SX_PAD || cb >= SX_PAD || cd > SX_PAD || code > SX_PAD) begin
                    n_status  = ST_INVALID;
                    n_stopped = 1'b1;
                end else if (be17 >= cap17) begin
                    n_stopped = 1'b1;
                end else if (cd == SX_PAD) begin
                    nb        = 2'd1;
                    n_stopped = 1'b1;
                end else if (be17 + 17'd1 >= cap17) begin
                    nb        = 2'd1;
                    n_stopped = 1'b1;
                end else if (code == SX_PAD) begin
                    nb        = 2'd2;
                    n_stopped = 1'b1;
                end else if (be17 + 17'd2 >= cap17) begin
                    nb        = 2'd2;
                    n_stopped = 1'b1;
                end else begin
                    nb = 2'd3;
                end
            end
        end

        rem_next = (s_rem != 16'd0) ? s_rem - 16'd1 : 16'd0;
        ending   = in_ch.last_char || (rem_next == 16'd0);

        o_cmd.data[0]     = {ca[5:0], cb[5:4]};
        o_cmd.data[1]     = {cb[3:0], cd[5:2]};
        o_cmd.data[2]     = {cd[1:0], code[5:0]};
        o_cmd.nbytes      = nb;
        o_cmd.base_count  = s_bytes;
        o_cmd.has_status  = ending;
        o_cmd.status      = n_status;
        o_cmd.final_count = s_bytes + {14'd0, nb};
        o_push            = accept && ((nb != 2'd0) || ending);

        if (ending) begin
            n_in_msg    = 1'b0;
            n_phase     = 2'd0;
            n_remaining = 16'd0;
            n_bytes     = 16'd0;
            n_stopped   = 1'b0;
            n_status    = ST_OK;
        end else begin
            n_in_msg    = 1'b1;
            n_remaining = rem_next;
            n_bytes     = s_bytes + {14'd0, nb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg    <= 1'b0;
            r_phase     <= 2'd0;
            r_remaining <= 16'd0;
            r_bytes     <= 16'd0;
            r_stopped   <= 1'b0;
            r_status    <= ST_OK;
        end else if (accept) begin
            r_in_msg    <= n_in_msg;
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_bytes     <= n_bytes;
            r_stopped   <= n_stopped;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

[src/bsd_queue.sv]
// Short command queue between the front end and the output sequencer.
`timescale 1ns / 1ps
module bsd_queue #(
    parameter int DEPTH = bsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bsd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output bsd_pkg::t_cmd o_head
);
    import bsd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[src/bsd_back.sv]
// Back end: expands queued commands into data and status words through an output register.
`timescale 1ns / 1ps
module bsd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsd_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    bsd_out_if.source     out_ch
);
    import bsd_pkg::*;

    logic [1:0]  r_idx;
    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_data;
    logic [1:0]  r_status;
    logic [15:0] r_count;
    logic        r_last;

    logic        load;
    logic [2:0]  last_idx;
    logic        is_data;
    logic [7:0]  sel_byte;

    always_comb begin
        load     = !i_empty && (!r_valid || out_ch.ready);
        last_idx = {1'b0, i_head.nbytes} + {2'b00, i_head.has_status} - 3'd1;
        is_data  = r_idx < i_head.nbytes;
        o_pop    = load && ({1'b0, r_idx} == last_idx);
        case (r_idx)
            2'd0:    sel_byte = i_head.data[0];
            2'd1:    sel_byte = i_head.data[1];
            2'd2:    sel_byte = i_head.data[2];
            default: sel_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= o_pop ? 2'd0 : r_idx + 2'd1;
            end else if (out_ch.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (is_data) begin
                r_kind   <= 1'b0;
                r_data   <= sel_byte;
                r_status <= ST_OK;
                r_count  <= i_head.base_count + {14'd0, r_idx} + 16'd1;
                r_last   <= 1'b0;
            end else begin
                r_kind   <= 1'b1;
                r_data   <= 8'd0;
                r_status <= i_head.status;
                r_count  <= i_head.final_count;
                r_last   <= 1'b1;
            end
        end
    end

    assign out_ch.valid       = r_valid;
    assign out_ch.item_kind   = r_kind;
    assign out_ch.data_byte   = r_data;
    assign out_ch.status_code = r_status;
    assign out_ch.byte_count  = r_count;
    assign out_ch.last_item   = r_last;

endmodule

[src/base64_stream_decoder.sv]
// Top level of the streaming base64 decoder with its configuration register port.
//
// Usage: characters arrive on in_ch, one word per character; total_chars is sampled on
// the first character of a message and last_char closes a message early. Decoded bytes
// and one closing status word per message leave on out_ch in order. The register at byte
// address 0 holds the output capacity; the user writes it through the APB-style port only
// while the stream is idle, unenforced by the block; reads return it, pready is always high.
// Throughput: one character is accepted every cycle while the command queue has room.
// Each character yields one queue command at most, and the output sequencer emits one
// word per cycle while out_ch is ready; a group of four characters gives up to four words.
// The first word caused by a character passes the command queue, written at the edge
// that accepts the character, and then the output register, which loads from the queue
// head; a stall on out_ch holds it back further.
// Reset clears message state, the queue and the output valid flag; capacity resets to 0.
// When the receiver stalls, the output register holds its word, the queue fills after
// QUEUE_DEPTH commands, and then in_ch.ready drops until a command leaves the queue.
`timescale 1ns / 1ps
module base64_stream_decoder #(
    parameter int MAX_CHARS   = bsd_pkg::MAX_CHARS_DEF,
    parameter int QUEUE_DEPTH = bsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    bsd_in_if.sink      in_ch,
    bsd_out_if.source   out_ch
);
    import bsd_pkg::*;

    logic [15:0] r_capacity;
    logic        push, pop, full, empty;
    t_cmd        cmd_in, cmd_head;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 16'd0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = {16'd0, r_capacity};
        end
    end

    bsd_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .in_ch      (in_ch),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    bsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (cmd_head)
    );

    bsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (cmd_head),
        .i_empty (empty),
        .o_pop   (pop),
        .out_ch  (out_ch)
    );

endmodule
